// ===== sv/mlq_pkg.sv =====
// shared types and codes for the multilevel sorted ready queue
// no dependencies; every other file refers to it by scoped names
package mlq_pkg;

  localparam int ID_W  = 8;
  localparam int ARR_W = 32;
  localparam int LVL_W = 3;
  localparam int ST_W  = 2;
  localparam int CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // field order gives the (level, arrival, id) sort key
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [ARR_W-1:0] arrival;
    logic [ID_W-1:0]  task_id;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
    logic report;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/mlq_req_if.sv =====
// request channel of the ready queue: valid/ready plus the command word
// depends on mlq_pkg for field widths
interface mlq_req_if;
  logic                      valid;
  logic                      ready;
  logic [mlq_pkg::CMD_W-1:0] cmd;
  logic [mlq_pkg::ID_W-1:0]  task_id;
  logic [mlq_pkg::ARR_W-1:0] arrival;
  logic [mlq_pkg::LVL_W-1:0] level;

  modport source (output valid, cmd, task_id, arrival, level, input ready);
  modport sink   (input valid, cmd, task_id, arrival, level, output ready);
endinterface

// ===== sv/mlq_rsp_if.sv =====
// response channel of the ready queue: valid/ready plus the result word
// depends on mlq_pkg for field widths
interface mlq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mlq_pkg::ST_W-1:0]  status;
  logic [mlq_pkg::ID_W-1:0]  head_id;
  logic [mlq_pkg::ARR_W-1:0] head_arrival;
  logic [mlq_pkg::LVL_W-1:0] head_level;
  logic                      all_empty;
  logic [mlq_pkg::LVL_W-1:0] top_level;

  modport source (output valid, status, head_id, head_arrival, head_level,
                  all_empty, top_level, input ready);
  modport sink   (input valid, status, head_id, head_arrival, head_level,
                  all_empty, top_level, output ready);
endinterface

// ===== sv/multilevel_sorted_ready_queue.sv =====
// top level of the multilevel sorted ready queue
// depends on mlq_pkg, mlq_req_if, mlq_rsp_if, mlq_ctrl, mlq_datapath
//
//   channel  dir  word
//   req      in   cmd, task_id, arrival, level
//   rsp      out  status, head_id, head_arrival, head_level, all_empty, top_level
//
// one command at a time; the scan that sets the time from accept to result
// reads one table entry per cycle through the single memory read port,
// with a single key comparator
// req.ready is high only between commands; the next word is taken while
// a finished result still sits in the rsp register
// a stalled rsp holds the sequencer before its report step
// rst is synchronous and empties every level at once through the valid bits
module multilevel_sorted_ready_queue #(
  parameter int ENTRIES = 32,
  parameter int LEVELS  = 5
) (
  input logic       clk,
  input logic       rst,
  mlq_req_if.sink   req,
  mlq_rsp_if.source rsp
);

  mlq_pkg::dp_cmd_t  dp_cmd;
  mlq_pkg::dp_stat_t dp_stat;

  mlq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  mlq_datapath #(
    .ENTRIES (ENTRIES),
    .LEVELS  (LEVELS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .dp_cmd           (dp_cmd),
    .dp_stat          (dp_stat),
    .in_cmd           (req.cmd),
    .in_task_id       (req.task_id),
    .in_arrival       (req.arrival),
    .in_level         (req.level),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_status       (rsp.status),
    .out_head_id      (rsp.head_id),
    .out_head_arrival (rsp.head_arrival),
    .out_head_level   (rsp.head_level),
    .out_all_empty    (rsp.all_empty),
    .out_top_level    (rsp.top_level)
  );

endmodule

// ===== sv/mlq_ctrl.sv =====
// sequencer of the ready queue: accept, scan, commit, report
// depends on mlq_pkg for the command and status structs
module mlq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output mlq_pkg::dp_cmd_t  dp_cmd,
  input  mlq_pkg::dp_stat_t dp_stat
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    dp_cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.start = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        dp_cmd.scan = 1'b1;
        if (dp_stat.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        dp_cmd.commit = 1'b1;
        state_next    = S_REPORT;
      end
      S_REPORT: begin
        // wait for the output register to free up
        if (dp_stat.out_free) begin
          dp_cmd.report = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ===== sv/mlq_datapath.sv =====
// entry store, per-level counts, one-entry-per-cycle scan and result register
// depends on mlq_pkg; driven by mlq_ctrl through dp_cmd_t / dp_stat_t
module mlq_datapath #(
  parameter int ENTRIES = 32,
  parameter int LEVELS  = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mlq_pkg::dp_cmd_t          dp_cmd,
  output mlq_pkg::dp_stat_t         dp_stat,
  input  logic [mlq_pkg::CMD_W-1:0] in_cmd,
  input  logic [mlq_pkg::ID_W-1:0]  in_task_id,
  input  logic [mlq_pkg::ARR_W-1:0] in_arrival,
  input  logic [mlq_pkg::LVL_W-1:0] in_level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mlq_pkg::ST_W-1:0]  out_status,
  output logic [mlq_pkg::ID_W-1:0]  out_head_id,
  output logic [mlq_pkg::ARR_W-1:0] out_head_arrival,
  output logic [mlq_pkg::LVL_W-1:0] out_head_level,
  output logic                      out_all_empty,
  output logic [mlq_pkg::LVL_W-1:0] out_top_level
);

  localparam int AW  = $clog2(ENTRIES);
  localparam int IW  = $clog2(ENTRIES + 1);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [mlq_pkg::LVL_W-1:0] MAX_LVL = mlq_pkg::LVL_W'(LEVELS - 1);

  // storage
  mlq_pkg::entry_t    mem [ENTRIES];
  logic [ENTRIES-1:0] vbits;
  logic [CW-1:0]      lvl_cnt [LEVELS];

  // latched command word
  mlq_pkg::cmd_e_t           cur_cmd;
  logic [mlq_pkg::ID_W-1:0]  cur_id;
  logic [mlq_pkg::ARR_W-1:0] cur_arr;
  logic [mlq_pkg::LVL_W-1:0] cur_lvl;

  // scan pipeline
  logic [IW-1:0]   issue_cnt;
  logic            pipe_act;
  logic            pipe_vb;
  logic [AW-1:0]   pipe_idx;
  mlq_pkg::entry_t rd_q;

  // scan results
  logic            hit;
  logic [AW-1:0]   hit_idx;
  logic            free_v;
  logic [AW-1:0]   free_idx;
  logic            best_v;
  logic [AW-1:0]   best_idx;
  mlq_pkg::entry_t best;
  logic            found;

  // result held between commit and report
  mlq_pkg::status_t          res_status;
  logic [mlq_pkg::ID_W-1:0]  res_id;
  logic [mlq_pkg::ARR_W-1:0] res_arr;
  logic [mlq_pkg::LVL_W-1:0] res_lvl;

  logic                      issuing;
  logic                      cmp_live;
  logic                      same_id;
  logic                      same_lvl;
  logic                      rm_clr;
  logic                      ins_we;
  logic                      ins_new;
  logic                      pop_clr;
  logic [AW-1:0]             waddr;
  mlq_pkg::entry_t           wdata;
  logic [mlq_pkg::LVL_W-1:0] top_lvl;
  logic                      none_left;

  assign issuing  = dp_cmd.scan && (issue_cnt != IW'(ENTRIES));
  assign cmp_live = dp_cmd.scan && pipe_act && pipe_vb;
  assign same_id  = (rd_q.task_id == cur_id);
  assign same_lvl = (rd_q.level == cur_lvl);
  assign rm_clr   = cmp_live && (cur_cmd == mlq_pkg::CMD_REMOVE) && same_id;

  assign ins_we  = dp_cmd.commit && (cur_cmd == mlq_pkg::CMD_INSERT) && (hit || free_v);
  assign ins_new = ins_we && !hit;
  assign pop_clr = dp_cmd.commit && (cur_cmd == mlq_pkg::CMD_POP) && best_v;
  assign waddr   = hit ? hit_idx : free_idx;
  assign wdata   = '{level: cur_lvl, arrival: cur_arr, task_id: cur_id};

  assign dp_stat.scan_done = (issue_cnt == IW'(ENTRIES)) && !pipe_act;
  assign dp_stat.out_free  = !out_valid || out_ready;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ins_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[issue_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      pipe_act  <= 1'b0;
    end else if (dp_cmd.start) begin
      issue_cnt <= '0;
      pipe_act  <= 1'b0;
    end else if (dp_cmd.scan) begin
      pipe_act <= issuing;
      if (issuing) begin
        issue_cnt <= issue_cnt + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_vb  <= vbits[issue_cnt[AW-1:0]];
    pipe_idx <= issue_cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      cur_cmd <= mlq_pkg::cmd_e_t'(in_cmd);
      cur_id  <= in_task_id;
      cur_arr <= in_arrival;
      cur_lvl <= (in_level > MAX_LVL) ? MAX_LVL : in_level;
      hit     <= 1'b0;
      free_v  <= 1'b0;
      best_v  <= 1'b0;
      found   <= 1'b0;
    end else if (dp_cmd.scan && pipe_act) begin
      if (pipe_vb) begin
        case (cur_cmd) inside
          mlq_pkg::CMD_INSERT: begin
            if (same_id && same_lvl) begin
              hit     <= 1'b1;
              hit_idx <= pipe_idx;
            end
          end
          mlq_pkg::CMD_POP, mlq_pkg::CMD_PEEK: begin
            if (!best_v || (rd_q < best)) begin
              best_v   <= 1'b1;
              best_idx <= pipe_idx;
              best     <= rd_q;
            end
          end
          mlq_pkg::CMD_REMOVE: begin
            if (same_id) begin
              found <= 1'b1;
            end
          end
          default: ;
        endcase
      end else if (!free_v) begin
        free_v   <= 1'b1;
        free_idx <= pipe_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (rm_clr) begin
      vbits[pipe_idx] <= 1'b0;
    end else if (ins_new) begin
      vbits[free_idx] <= 1'b1;
    end else if (pop_clr) begin
      vbits[best_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        lvl_cnt[l] <= '0;
      end
    end else if (rm_clr) begin
      lvl_cnt[rd_q.level[LIW-1:0]] <= lvl_cnt[rd_q.level[LIW-1:0]] - CW'(1);
    end else if (ins_new) begin
      lvl_cnt[cur_lvl[LIW-1:0]] <= lvl_cnt[cur_lvl[LIW-1:0]] + CW'(1);
    end else if (pop_clr) begin
      lvl_cnt[best.level[LIW-1:0]] <= lvl_cnt[best.level[LIW-1:0]] - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      res_status <= mlq_pkg::ST_OK;
      res_id     <= '0;
      res_arr    <= '0;
      res_lvl    <= '0;
      case (cur_cmd) inside
        mlq_pkg::CMD_INSERT: begin
          if (!ins_we) begin
            res_status <= mlq_pkg::ST_FULL;
          end
        end
        mlq_pkg::CMD_POP, mlq_pkg::CMD_PEEK: begin
          if (best_v) begin
            res_id  <= best.task_id;
            res_arr <= best.arrival;
            res_lvl <= best.level;
          end else begin
            res_status <= mlq_pkg::ST_NONE;
          end
        end
        mlq_pkg::CMD_REMOVE: begin
          if (!found) begin
            res_status <= mlq_pkg::ST_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // lowest level with a nonzero count
  always_comb begin
    top_lvl   = mlq_pkg::LVL_W'(LEVELS);
    none_left = 1'b1;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (lvl_cnt[l] != '0) begin
        top_lvl   = mlq_pkg::LVL_W'(l);
        none_left = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.report) begin
      out_status       <= res_status;
      out_head_id      <= res_id;
      out_head_arrival <= res_arr;
      out_head_level   <= res_lvl;
      out_all_empty    <= none_left;
      out_top_level    <= top_lvl;
    end
  end

endmodule

// ===== sv/mlq_checker.sv =====
// port-level checks for the ready queue, bound to the top level
// depends on mlq_pkg and multilevel_sorted_ready_queue
module mlq_checker #(
  parameter int LEVELS = 5
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [mlq_pkg::ST_W-1:0]  rsp_status,
  input logic [mlq_pkg::ID_W-1:0]  rsp_head_id,
  input logic [mlq_pkg::ARR_W-1:0] rsp_head_arrival,
  input logic [mlq_pkg::LVL_W-1:0] rsp_head_level,
  input logic                      rsp_all_empty,
  input logic [mlq_pkg::LVL_W-1:0] rsp_top_level
);

  localparam logic [mlq_pkg::LVL_W-1:0] NO_LVL = mlq_pkg::LVL_W'(LEVELS);

  // a failed command carries no head entry
  a_fail_no_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != mlq_pkg::ST_OK) |->
      (rsp_head_id == '0) && (rsp_head_arrival == '0) && (rsp_head_level == '0))
    else $error("failed command reports a head entry");

  // empty flag and top level agree
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_all_empty == (rsp_top_level == NO_LVL)))
    else $error("all_empty disagrees with top_level");

  // a full store cannot be empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == mlq_pkg::ST_FULL) |-> !rsp_all_empty)
    else $error("store full reported with no entries");

  // one command in flight: no new word right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a command is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_head_id) && $stable(rsp_head_arrival) && $stable(rsp_top_level))
    else $error("stalled result word changed");

endmodule

bind multilevel_sorted_ready_queue mlq_checker #(
  .LEVELS (LEVELS)
) u_mlq_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_head_id      (rsp.head_id),
  .rsp_head_arrival (rsp.head_arrival),
  .rsp_head_level   (rsp.head_level),
  .rsp_all_empty    (rsp.all_empty),
  .rsp_top_level    (rsp.top_level)
);
